FILE: sv/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CFRA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define CFRA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  `CFRA_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

// Check that a condition implies another in the next cycle.
`define CFRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `CFRA_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

FILE: sv/cfra_pkg.sv
package cfra_pkg;

  localparam int unsigned MaxRangesDef = 16;
  localparam logic [31:0] PoolReset    = 32'd65536;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_DOUBLE    = 3'd2,
    ST_ZERO      = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_IDX,
    OP_STATUS,
    OP_ALLOC_SHRINK,
    OP_ALLOC_EXACT,
    OP_ADV,
    OP_FREE_EMPTY,
    OP_TOUCH_HI,
    OP_TOUCH_WR,
    OP_MERGE_HI,
    OP_MERGE_LO,
    OP_GROW,
    OP_INS_PREP,
    OP_APPEND,
    OP_SHD_RD,
    OP_SHD_WR,
    OP_SHD_END,
    OP_SHU_RD,
    OP_SHU_WR,
    OP_SHU_END
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic cnt_zero;
    logic fit;
    logic exact;
    logic end_eq;
    logic start_eq;
    logic start_gt;
    logic grow;
    logic full;
    logic merge_lo;
    logic last;
    logic end_lt;
    logic merge_hi;
    logic shd_more;
    logic shu_more;
  } flags_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } range_t;

endpackage

FILE: sv/cfra_ctrl.sv
module cfra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  cfra_pkg::flags_t flags_i,
  output cfra_pkg::cmd_t  cmd_o,
  output logic            busy,
  output logic            done_o
);
  import cfra_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CHK  = 9'b000000010,
    S_EVAL = 9'b000000100,
    S_MRG  = 9'b000001000,
    S_SHD  = 9'b000010000,
    S_SHDW = 9'b000100000,
    S_SHU  = 9'b001000000,
    S_SHUW = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OP_NONE, code: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        if (!flags_i.is_free) begin
          if (flags_i.cnt_zero) begin
            cmd_o = '{op: OP_STATUS, code: ST_NO_FIT};
            state_d = S_DONE;
          end else begin
            cmd_o.op = OP_RD_IDX;
            state_d  = S_EVAL;
          end
        end else if (flags_i.size_zero) begin
          cmd_o = '{op: OP_STATUS, code: ST_ZERO};
          state_d = S_DONE;
        end else if (flags_i.cnt_zero) begin
          cmd_o.op = OP_FREE_EMPTY;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_RD_IDX;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!flags_i.is_free) begin
          if (flags_i.fit) begin
            if (flags_i.exact) begin
              cmd_o.op = OP_ALLOC_EXACT;
              state_d  = S_SHD;
            end else begin
              cmd_o.op = OP_ALLOC_SHRINK;
              state_d  = S_DONE;
            end
          end else if (flags_i.last) begin
            cmd_o = '{op: OP_STATUS, code: ST_NO_FIT};
            state_d = S_DONE;
          end else begin
            cmd_o.op = OP_ADV;
          end
        end else if (flags_i.end_eq) begin
          cmd_o.op = OP_TOUCH_HI;
          state_d  = S_MRG;
        end else if (flags_i.start_eq) begin
          cmd_o = '{op: OP_STATUS, code: ST_DOUBLE};
          state_d = S_DONE;
        end else if (flags_i.start_gt) begin
          if (flags_i.full && !flags_i.grow) begin
            cmd_o = '{op: OP_STATUS, code: ST_FULL};
            state_d = S_DONE;
          end else if (flags_i.merge_lo) begin
            // lower neighbor absorbs the range; a grown entry then drops
            cmd_o.op = OP_MERGE_LO;
            state_d  = flags_i.grow ? S_SHD : S_DONE;
          end else if (flags_i.grow) begin
            cmd_o.op = OP_GROW;
            state_d  = S_DONE;
          end else begin
            cmd_o.op = OP_INS_PREP;
            state_d  = S_SHU;
          end
        end else if (flags_i.last && flags_i.end_lt) begin
          if (flags_i.full) begin
            cmd_o = '{op: OP_STATUS, code: ST_FULL};
          end else begin
            cmd_o.op = OP_APPEND;
          end
          state_d = S_DONE;
        end else if (flags_i.last) begin
          cmd_o = '{op: OP_STATUS, code: ST_NOT_FOUND};
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_ADV;
        end
      end
      S_MRG: begin
        if (flags_i.merge_hi) begin
          cmd_o.op = OP_MERGE_HI;
          state_d  = S_SHD;
        end else begin
          cmd_o.op = OP_TOUCH_WR;
          state_d  = S_DONE;
        end
      end
      S_SHD: begin
        if (flags_i.shd_more) begin
          cmd_o.op = OP_SHD_RD;
          state_d  = S_SHDW;
        end else begin
          cmd_o.op = OP_SHD_END;
          state_d  = S_DONE;
        end
      end
      S_SHDW: begin
        cmd_o.op = OP_SHD_WR;
        state_d  = S_SHD;
      end
      S_SHU: begin
        if (flags_i.shu_more) begin
          cmd_o.op = OP_SHU_RD;
          state_d  = S_SHUW;
        end else begin
          cmd_o.op = OP_SHU_END;
          state_d  = S_DONE;
        end
      end
      S_SHUW: begin
        cmd_o.op = OP_SHU_WR;
        state_d  = S_SHU;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

FILE: sv/cfra_dpath.sv
module cfra_dpath #(
  parameter int unsigned MAX_RANGES = cfra_pkg::MaxRangesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfra_pkg::cmd_t   cmd_i,
  output cfra_pkg::flags_t flags_o,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             func_i,
  input  logic [31:0]      req_size_i,
  input  logic [31:0]      block_offset_i,
  output logic [2:0]       status_o,
  output logic [31:0]      alloc_offset_o,
  output logic [31:0]      free_total_o
);
  import cfra_pkg::*;

  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);

  range_t          mem [MAX_RANGES];
  range_t          mem_q;
  logic            hit_q;
  logic            init_q;
  logic [31:0]     pool_q;
  logic [CW-1:0]   cnt_q;
  logic [31:0]     sum_q;
  logic            func_q;
  logic [31:0]     size_q;
  logic [31:0]     off_q;
  logic [AW-1:0]   idx_q;
  logic [AW-1:0]   ptr_q;
  range_t          prev_q;
  range_t          cur_q;
  status_e         status_q;
  logic [31:0]     where_q;

  range_t          rd;
  logic [AW-1:0]   ra;
  logic            we;
  logic [AW-1:0]   wa;
  range_t          wd;
  logic [32:0]     end33;
  logic [32:0]     off33;
  logic [32:0]     prev_end33;
  logic [32:0]     cur_end33;
  logic [CW-1:0]   idx_inc;

  // entry 0 reads as the initial range until it is first written
  assign rd = hit_q ? range_t'{start: 32'd0, len: pool_q} : mem_q;

  assign end33      = {1'b0, rd.start} + {1'b0, rd.len};
  assign off33      = {1'b0, off_q};
  assign prev_end33 = {1'b0, prev_q.start} + {1'b0, prev_q.len};
  assign cur_end33  = {1'b0, cur_q.start} + {1'b0, cur_q.len};
  assign idx_inc    = CW'(idx_q) + CW'(1);

  always_comb begin
    flags_o.is_free   = func_q;
    flags_o.size_zero = (size_q == 32'd0);
    flags_o.cnt_zero  = (cnt_q == '0);
    flags_o.fit       = (rd.len >= size_q);
    flags_o.exact     = (rd.len == size_q);
    flags_o.end_eq    = (end33 == off33);
    flags_o.start_eq  = (rd.start == off_q);
    flags_o.start_gt  = (rd.start > off_q);
    flags_o.grow      = ((off33 + {1'b0, size_q}) == {1'b0, rd.start});
    flags_o.full      = (cnt_q >= CW'(MAX_RANGES));
    flags_o.merge_lo  = (idx_q != '0) && (prev_end33 == off33);
    flags_o.last      = (idx_inc >= cnt_q);
    flags_o.end_lt    = (end33 < off33);
    flags_o.merge_hi  = (idx_inc < cnt_q) && ({1'b0, rd.start} == cur_end33);
    flags_o.shd_more  = ((CW'(ptr_q) + CW'(1)) < cnt_q);
    flags_o.shu_more  = (ptr_q > idx_q);
  end

  always_comb begin
    case (cmd_i.op)
      OP_ADV, OP_TOUCH_HI: ra = idx_q + AW'(1);
      OP_SHD_RD:           ra = ptr_q + AW'(1);
      OP_SHU_RD:           ra = ptr_q - AW'(1);
      default:             ra = idx_q;
    endcase
  end

  always_comb begin
    we = 1'b1;
    wa = idx_q;
    wd = '{start: off_q, len: size_q};
    case (cmd_i.op)
      OP_ALLOC_SHRINK: wd = '{start: rd.start + size_q, len: rd.len - size_q};
      OP_FREE_EMPTY:   wa = '0;
      OP_TOUCH_WR:     wd = cur_q;
      OP_MERGE_HI:     wd = '{start: cur_q.start, len: cur_q.len + rd.len};
      OP_MERGE_LO: begin
        wa = idx_q - AW'(1);
        wd = '{start: prev_q.start,
               len: prev_q.len + (flags_o.grow ? rd.len + size_q : size_q)};
      end
      OP_GROW:         wd = '{start: off_q, len: rd.len + size_q};
      OP_APPEND:       wa = cnt_q[AW-1:0];
      OP_SHD_WR, OP_SHU_WR: begin
        wa = ptr_q;
        wd = rd;
      end
      OP_SHU_END:      wa = idx_q;
      default:         we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      init_q <= 1'b1;
      pool_q <= PoolReset;
      cnt_q  <= CW'(1);
      sum_q  <= PoolReset;
    end else begin
      hit_q <= init_q && (ra == '0);
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
        cnt_q  <= CW'(1);
        sum_q  <= cfg_wdata_i;
        init_q <= 1'b1;
      end else begin
        if (we && (wa == '0)) begin
          init_q <= 1'b0;
        end
        case (cmd_i.op)
          OP_ALLOC_SHRINK, OP_ALLOC_EXACT: sum_q <= sum_q - size_q;
          OP_FREE_EMPTY: begin
            cnt_q <= CW'(1);
            sum_q <= sum_q + size_q;
          end
          OP_TOUCH_HI, OP_MERGE_LO, OP_GROW, OP_INS_PREP: sum_q <= sum_q + size_q;
          OP_APPEND, OP_SHU_END: begin
            cnt_q <= cnt_q + CW'(1);
            if (cmd_i.op == OP_APPEND) begin
              sum_q <= sum_q + size_q;
            end
          end
          OP_SHD_END: cnt_q <= cnt_q - CW'(1);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q   <= func_i;
        size_q   <= req_size_i;
        off_q    <= block_offset_i;
        idx_q    <= '0;
        status_q <= ST_OK;
        where_q  <= 32'd0;
      end
      OP_STATUS:       status_q <= cmd_i.code;
      OP_ALLOC_SHRINK: where_q <= rd.start;
      OP_ALLOC_EXACT: begin
        where_q <= rd.start;
        ptr_q   <= idx_q;
      end
      OP_ADV: begin
        prev_q <= rd;
        idx_q  <= idx_q + AW'(1);
      end
      OP_TOUCH_HI:  cur_q <= '{start: rd.start, len: rd.len + size_q};
      OP_MERGE_HI:  ptr_q <= idx_q + AW'(1);
      OP_MERGE_LO:  ptr_q <= idx_q;
      OP_INS_PREP:  ptr_q <= cnt_q[AW-1:0];
      OP_SHD_WR:    ptr_q <= ptr_q + AW'(1);
      OP_SHU_WR:    ptr_q <= ptr_q - AW'(1);
      default: ;
    endcase
  end

  assign status_o       = status_q;
  assign alloc_offset_o = where_q;
  assign free_total_o   = sum_q;

endmodule

FILE: sv/coalescing_free_range_allocator.sv
// First-fit allocator over a sorted table of free ranges with coalescing on
// free. Pulse start while busy is low to issue a request; exactly one result
// follows, shown for a single cycle with done_o high, and it cannot be held
// off, so capture it on that cycle. A request loads its operands, checks them,
// then scans the table one entry per step; a free that touches a range from
// above adds an upward merge check, and removing or inserting an entry moves
// each later entry with a read step and a write step, then closes the shift
// with a final step before the result. The registered read of the range
// memory is why each moved entry needs both steps. Writing cfg_wdata_i with
// cfg_we_i resets the table to one range covering the pool, taking effect at once.
`include "assert_macros.svh"

module coalescing_free_range_allocator #(
  parameter int unsigned MAX_RANGES = cfra_pkg::MaxRangesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [31:0] req_size_i,
  input  logic [31:0] block_offset_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] alloc_offset_o,
  output logic [31:0] free_total_o
);
  import cfra_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  cfra_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .flags_i (flags),
    .cmd_o   (cmd),
    .busy    (busy),
    .done_o  (done_o)
  );

  cfra_dpath #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .flags_o        (flags),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .func_i         (func_i),
    .req_size_i     (req_size_i),
    .block_offset_i (block_offset_i),
    .status_o       (status_o),
    .alloc_offset_o (alloc_offset_o),
    .free_total_o   (free_total_o)
  );

  `CFRA_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy, "result beat outside a request")
  `CFRA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "request not taken")
  `CFRA_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy, "no return to idle after result")
  `CFRA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, done_o && (status_o != ST_OK), alloc_offset_o == 32'd0, "offset on failed request")

endmodule

FILE: test/tb_coalescing_free_range_allocator.sv
`timescale 1ns / 1ps

module tb_coalescing_free_range_allocator;
  import cfra_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned SETTLE = 3 * SLOTS + 12;

  typedef struct {
    status_e     status;
    logic [31:0] offset;
    logic [31:0] total;
  } alloc_result_t;

  typedef struct {
    logic [31:0] off;
    logic [31:0] len;
  } live_block_t;

  typedef struct {
    logic        func;
    logic [31:0] size;
    logic [31:0] off;
    bit          known;
    status_e     status;
    logic [31:0] offset;
    logic [31:0] total;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        func_i = 1'b0;
  logic [31:0] req_size_i = '0;
  logic [31:0] block_offset_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] alloc_offset_o;
  logic [31:0] free_total_o;

  coalescing_free_range_allocator u_dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .req_size_i, .block_offset_i,
    .cfg_we_i, .cfg_wdata_i, .done_o, .status_o, .alloc_offset_o, .free_total_o
  );

  always #2 clk_i = ~clk_i;

  // free range table mirror
  logic [31:0]   rng_start[SLOTS];
  logic [31:0]   rng_len[SLOTS];
  int unsigned   rng_cnt;
  logic [31:0]   free_sum;
  logic [31:0]   pool;
  alloc_result_t pending[$];
  alloc_result_t last_seen;
  live_block_t   live[$];
  int unsigned   errors = 0;
  int unsigned   idle_pct = 0;

  function automatic logic [32:0] range_end(int unsigned k);
    return {1'b0, rng_start[k]} + {1'b0, rng_len[k]};
  endfunction

  function automatic void reinit_table(logic [31:0] size);
    pool = size;
    foreach (rng_start[k]) begin
      rng_start[k] = '0;
      rng_len[k] = '0;
    end
    rng_len[0] = size;
    rng_cnt = 1;
    free_sum = size;
  endfunction

  function automatic void remove_range(int unsigned pos);
    for (int unsigned k = pos; k + 1 < rng_cnt; k++) begin
      rng_start[k] = rng_start[k+1];
      rng_len[k] = rng_len[k+1];
    end
    rng_cnt--;
  endfunction

  function automatic void insert_range(int unsigned pos, logic [31:0] s, logic [31:0] l);
    for (int unsigned k = rng_cnt; k > pos; k--) begin
      rng_start[k] = rng_start[k-1];
      rng_len[k] = rng_len[k-1];
    end
    rng_start[pos] = s;
    rng_len[pos] = l;
    rng_cnt++;
  endfunction

  function automatic status_e take_first_fit(logic [31:0] size, output logic [31:0] where);
    where = '0;
    for (int unsigned i = 0; i < rng_cnt; i++) begin
      if (rng_len[i] >= size) begin
        where = rng_start[i];
        if (rng_len[i] == size) remove_range(i);
        else begin
          rng_start[i] += size;
          rng_len[i] -= size;
        end
        free_sum -= size;
        return ST_OK;
      end
    end
    return ST_NO_FIT;
  endfunction

  function automatic status_e give_back(logic [31:0] size, logic [31:0] off);
    if (size == 0) return ST_ZERO;
    if (rng_cnt == 0) begin
      insert_range(0, off, size);
      free_sum += size;
      return ST_OK;
    end
    for (int unsigned i = 0; i < rng_cnt; i++) begin
      if (range_end(i) == {1'b0, off}) begin
        rng_len[i] += size;
        if (i + 1 < rng_cnt && {1'b0, rng_start[i+1]} == range_end(i)) begin
          rng_len[i] += rng_len[i+1];
          remove_range(i + 1);
        end
        free_sum += size;
        return ST_OK;
      end
      if (rng_start[i] == off) return ST_DOUBLE;
      if (rng_start[i] > off) begin
        if ({1'b0, off} + {1'b0, size} == {1'b0, rng_start[i]}) begin
          rng_start[i] = off;
          rng_len[i] += size;
        end else begin
          if (rng_cnt >= SLOTS) return ST_FULL;
          insert_range(i, off, size);
        end
        if (i > 0 && range_end(i - 1) == {1'b0, rng_start[i]}) begin
          rng_len[i-1] += rng_len[i];
          remove_range(i);
        end
        free_sum += size;
        return ST_OK;
      end
      if (i + 1 >= rng_cnt && range_end(i) < {1'b0, off}) begin
        if (rng_cnt >= SLOTS) return ST_FULL;
        insert_range(rng_cnt, off, size);
        free_sum += size;
        return ST_OK;
      end
    end
    return ST_NOT_FOUND;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    alloc_result_t got;
    live_block_t   blk;
    if (!rst_ni) begin
      reinit_table(PoolReset);
    end else begin
      if (done_o) begin
        got.status = status_e'(status_o);
        got.offset = alloc_offset_o;
        got.total = free_total_o;
        last_seen = got;
        if (pending.size() == 0) begin
          $display("%0t: unexpected result status=%0d offset=%h total=%h", $time,
                   status_o, alloc_offset_o, free_total_o);
          errors++;
        end else begin
          want = pending.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            errors++;
          end
          if (alloc_offset_o !== want.offset) begin
            $display("%0t: alloc_offset expected %h actual %h", $time, want.offset,
                     alloc_offset_o);
            errors++;
          end
          if (free_total_o !== want.total) begin
            $display("%0t: free_total expected %h actual %h", $time, want.total,
                     free_total_o);
            errors++;
          end
        end
      end
      if (cfg_we_i) begin
        reinit_table(cfg_wdata_i);
        live.delete();
      end
      if (start && !busy) begin
        if (func_i == 1'b0) begin
          want.status = take_first_fit(req_size_i, want.offset);
          if (want.status == ST_OK && req_size_i != 0) begin
            blk.off = want.offset;
            blk.len = req_size_i;
            live.push_back(blk);
          end
        end else begin
          want.offset = '0;
          want.status = give_back(req_size_i, block_offset_i);
        end
        want.total = free_sum;
        pending.push_back(want);
      end
    end
  end

  task automatic issue(logic f, logic [31:0] size, logic [31:0] off);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    func_i <= f;
    req_size_i <= size;
    block_offset_i <= off;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_pool(logic [31:0] size);
    drain();
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned idx;
    live_block_t blk;
    logic [31:0] cut;
    pick = $urandom_range(99);
    if (pick < 15) begin
      issue(1'($urandom_range(1)), $urandom, $urandom);
    end else if (pick < 55 || live.size() == 0) begin
      // mostly small sizes, now and then the whole pool or more
      if ($urandom_range(19) == 0) issue(1'b0, pool + $urandom_range(1), $urandom);
      else issue(1'b0, $urandom_range(1, (pool > 64) ? pool / 12 : 4), $urandom);
    end else begin
      idx = $urandom_range(live.size() - 1);
      blk = live[idx];
      live.delete(idx);
      // return the whole block, or only its low or high part
      case ($urandom_range(3))
        0: begin
          cut = $urandom_range(1, blk.len);
          issue(1'b1, cut, blk.off);
        end
        1: begin
          cut = $urandom_range(0, blk.len - 1);
          issue(1'b1, blk.len - cut, blk.off + cut);
        end
        default: issue(1'b1, blk.len, blk.off);
      endcase
    end
  endtask

  dir_row_t dir_rows[] = '{
    '{1'b0, 32'd0,          32'd0,     1'b1, ST_OK,        32'd0, 32'd65536},
    '{1'b0, 32'd100,        32'd0,     1'b1, ST_OK,        32'd0, 32'd65436},
    '{1'b1, 32'd0,          32'd7,     1'b1, ST_ZERO,      32'd0, 32'd65436},
    '{1'b0, 32'hFFFFFFFF,   32'hFFFF,  1'b1, ST_NO_FIT,    32'd0, 32'd65436},
    '{1'b1, 32'd100,        32'd0,     1'b1, ST_OK,        32'd0, 32'd65536},
    '{1'b1, 32'd10,         32'd0,     1'b1, ST_DOUBLE,    32'd0, 32'd65536},
    '{1'b1, 32'd5,          32'd65536, 1'b1, ST_OK,        32'd0, 32'd65541},
    '{1'b1, 32'd5,          32'd100,   1'b1, ST_NOT_FOUND, 32'd0, 32'd65541},
    '{1'b0, 32'd65541,      32'd0,     1'b1, ST_OK,        32'd0, 32'd0},
    '{1'b0, 32'd1,          32'd0,     1'b1, ST_NO_FIT,    32'd0, 32'd0},
    '{1'b0, 32'd0,          32'd0,     1'b1, ST_NO_FIT,    32'd0, 32'd0},
    '{1'b1, 32'd10,         32'd200,   1'b1, ST_OK,        32'd0, 32'd10},
    '{1'b1, 32'd10,         32'd190,   1'b0, ST_OK,        32'd0, 32'd0},
    '{1'b1, 32'd10,         32'd300,   1'b0, ST_OK,        32'd0, 32'd0},
    '{1'b1, 32'd5,          32'd210,   1'b0, ST_OK,        32'd0, 32'd0},
    '{1'b1, 32'd85,         32'd215,   1'b0, ST_OK,        32'd0, 32'd0},
    '{1'b1, 32'd4,          32'd20,    1'b0, ST_OK,        32'd0, 32'd0},
    '{1'b1, 32'd6,          32'd50,    1'b0, ST_OK,        32'd0, 32'd0},
    '{1'b1, 32'd8,          32'd24,    1'b0, ST_OK,        32'd0, 32'd0},
    '{1'b1, 32'd1,          32'hFFFFFFFF, 1'b0, ST_OK,     32'd0, 32'd0},
    '{1'b1, 32'hFFFFFFFF,   32'd400,   1'b0, ST_OK,        32'd0, 32'd0},
    '{1'b0, 32'd10,         32'd0,     1'b0, ST_OK,        32'd0, 32'd0},
    '{1'b0, 32'd4,          32'd0,     1'b0, ST_OK,        32'd0, 32'd0}
  };

  logic [31:0] pool_plan[8] = '{32'd4096, 32'd1, 32'hFFFFFFFF, 32'd300,
                                32'd100000, 32'd64, 32'd65536, 32'hFFFFFFFF};
  int unsigned idle_plan[8] = '{0, 77, 0, 8, 0, 77, 8, 0};

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (dir_rows[r]) begin
      issue(dir_rows[r].func, dir_rows[r].size, dir_rows[r].off);
      if (dir_rows[r].known) begin
        drain();
        if (last_seen.status !== dir_rows[r].status || last_seen.offset !== dir_rows[r].offset
            || last_seen.total !== dir_rows[r].total) begin
          $display("%0t: row %0d expected %0d/%h/%h actual %0d/%h/%h", $time, r,
                   dir_rows[r].status, dir_rows[r].offset, dir_rows[r].total,
                   last_seen.status, last_seen.offset, last_seen.total);
          errors++;
        end
      end
    end
    live.delete();
    // fill the table with fragments until it reports full
    write_pool(32'd1000);
    for (int unsigned k = 0; k < SLOTS + 2; k++) issue(1'b1, 32'd2, 32'd1010 + 10 * k);
    foreach (pool_plan[p]) begin
      write_pool(pool_plan[p]);
      idle_pct = idle_plan[p];
      for (int unsigned n = 0; n < 115; n++) begin
        if (n == 60) drain();
        random_request();
      end
    end
    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/cfra_pkg.sv
sv/cfra_ctrl.sv
sv/cfra_dpath.sv
sv/coalescing_free_range_allocator.sv
test/tb_coalescing_free_range_allocator.sv
